// File: hdl/lrcs_pkg.sv
// Package with shared constants and types for the layered rectangle search.
package lrcs_pkg;
  localparam int CAPACITY_DEF = 1024;
  localparam int LAYERS_DEF = 32;

  typedef enum logic [2:0] {
    OP_CLEAR = 3'd0,
    OP_ADD   = 3'd1,
    OP_START = 3'd2,
    OP_NEXT  = 3'd3,
    OP_SXLO  = 3'd4,
    OP_SXHI  = 3'd5,
    OP_SYLO  = 3'd6,
    OP_SYHI  = 3'd7
  } opcode_t;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_NOMATCH = 2'd2;

  localparam logic [1:0] KIND_WIRE = 2'd0;
  localparam logic [1:0] KIND_VIA = 2'd1;

  // One stored rectangle.
  typedef struct packed {
    logic signed [31:0] xlo;
    logic signed [31:0] ylo;
    logic signed [31:0] xhi;
    logic signed [31:0] yhi;
    logic               via;
    logic signed [31:0] ident;
  } shape_t;

  // Query box presented to the compare unit.
  typedef struct packed {
    logic signed [31:0] xlo;
    logic signed [31:0] ylo;
    logic signed [31:0] xhi;
    logic signed [31:0] yhi;
    logic [1:0]         kind;
  } query_t;
endpackage

// File: hdl/lrcs_connect.sv
// Shared compare unit: decides whether one stored shape connects to the query box.
module lrcs_connect (
  input  lrcs_pkg::shape_t s,
  input  lrcs_pkg::query_t q,
  output logic             hit
);
  import lrcs_pkg::*;

  // Connection rule for a single candidate.
  always_comb begin
    hit = 1'b1;
    if (q.kind == KIND_VIA || s.via) begin
      hit = !(s.xlo >= q.xhi || q.xlo >= s.xhi || s.ylo >= q.yhi || q.ylo >= s.yhi);
    end else if (s.xlo > q.xhi || q.xlo > s.xhi || s.ylo > q.yhi || q.ylo > s.yhi) begin
      hit = 1'b0;
    end else if (q.kind == KIND_WIRE && (s.xlo == q.xhi || q.xlo == s.xhi)) begin
      if (s.yhi < q.ylo || s.ylo > q.yhi || (s.yhi < q.yhi && s.ylo < q.ylo) ||
          (s.yhi > q.yhi && s.ylo > q.ylo)) hit = 1'b0;
    end else if (q.kind == KIND_WIRE && (s.ylo == q.yhi || q.ylo == s.yhi)) begin
      if (s.xhi < q.xlo || s.xlo > q.xhi || (s.xhi < q.xhi && s.xlo < q.xlo) ||
          (s.xhi > q.xhi && s.xlo > q.xlo)) hit = 1'b0;
    end
  end
endmodule

// File: hdl/layered_rect_connect_search.sv
// Top level: shape table, sequencer and result register of the rectangle search.
// Every word gives one result word. Clear and add go from acceptance straight to
// the result; edits read the last matched entry and write it back if one is held. A
// start query or next scans the table through a single memory read port and the
// shared compare unit, reading and then testing each entry visited (up to CAPACITY
// entries). A next that has entries left to scan, whose query box lies apart from
// the layer's bounding box and is not a via query, ends without scanning. The block
// takes no new word until the result has been taken.
module layered_rect_connect_search #(
  parameter int CAPACITY = lrcs_pkg::CAPACITY_DEF,
  parameter int LAYERS = lrcs_pkg::LAYERS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         opcode,
  input  logic [4:0]         layer,
  input  logic signed [31:0] x_low,
  input  logic signed [31:0] y_low,
  input  logic signed [31:0] x_high,
  input  logic signed [31:0] y_high,
  input  logic               is_via,
  input  logic [1:0]         source_kind,
  input  logic signed [31:0] shape_id,
  input  logic signed [31:0] new_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] match_id,
  output logic               found,
  output logic [1:0]         status
);
  import lrcs_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = AW + 1;
  localparam int LW = (LAYERS > 1) ? $clog2(LAYERS) : 1;
  localparam logic [CW-1:0] CAP = CW'(CAPACITY);

  typedef enum logic [2:0] {S_IDLE, S_EXEC, S_READ, S_TEST, S_OUT} state_t;
  state_t state;

  // Memories: shape record and its layer, one read port.
  shape_t     mem [CAPACITY];
  logic [4:0] lmem [CAPACITY];
  shape_t     rd_shape;
  logic [4:0] rd_layer;
  logic [AW-1:0] wr_addr, rd_addr;
  logic       wr_en;
  shape_t     wr_data;

  // Latched input word.
  opcode_t op;
  logic [4:0] lay;
  logic signed [31:0] ixlo, iylo, ixhi, iyhi, iid, inv;
  logic ivia;
  logic [1:0] ikind;

  logic [CW-1:0] shape_count, scan_position, idx, last_match_index;
  logic last_match_valid;
  query_t qry;
  logic [4:0] qlayer;
  logic starting;

  // Per-layer bounding boxes.
  logic [LAYERS-1:0] lay_valid;
  logic signed [31:0] lxlo [LAYERS];
  logic signed [31:0] lylo [LAYERS];
  logic signed [31:0] lxhi [LAYERS];
  logic signed [31:0] lyhi [LAYERS];

  logic hit;
  lrcs_connect u_conn (.s(rd_shape), .q(qry), .hit(hit));

  // Layer numbers fold into the layer count through a small constant table.
  logic [4:0] lay_mod;
  always_comb begin
    lay_mod = '0;
    for (int i = 0; i < 32; i++) begin
      if (layer == 5'(i)) lay_mod = 5'(i % LAYERS);
    end
  end

  assign in_ready = (state == S_IDLE);

  // Only an add sets the layer of an entry; edits change coordinates alone.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
      if (op == OP_ADD) lmem[wr_addr] <= lay;
    end
    rd_shape <= mem[rd_addr];
    rd_layer <= lmem[rd_addr];
  end

  logic [LW-1:0] ql;
  assign ql = qlayer[LW-1:0];

  // Edit and add write data.
  always_comb begin
    wr_en = 1'b0;
    wr_addr = shape_count[AW-1:0];
    wr_data = rd_shape;
    rd_addr = idx[AW-1:0];
    if (state == S_EXEC && op == OP_ADD && shape_count < CAP) begin
      wr_en = 1'b1;
      wr_data = '{xlo: ixlo, ylo: iylo, xhi: ixhi, yhi: iyhi, via: ivia, ident: iid};
    end
    if (state == S_EXEC && (op == OP_SXLO || op == OP_SXHI || op == OP_SYLO ||
        op == OP_SYHI)) begin
      rd_addr = last_match_index[AW-1:0];
    end
    if (state == S_READ && (op == OP_SXLO || op == OP_SXHI || op == OP_SYLO ||
        op == OP_SYHI)) begin
      wr_addr = last_match_index[AW-1:0];
      wr_en = last_match_valid;
      case (op)
        OP_SXLO: wr_data.xlo = inv;
        OP_SXHI: wr_data.xhi = inv;
        OP_SYLO: wr_data.ylo = inv;
        default: wr_data.yhi = inv;
      endcase
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      shape_count <= '0;
      scan_position <= CAP;
      last_match_index <= '0;
      last_match_valid <= 1'b0;
      lay_valid <= '0;
      qry <= '0;
      qlayer <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op <= opcode_t'(opcode);
            lay <= lay_mod;
            ixlo <= x_low; iylo <= y_low; ixhi <= x_high; iyhi <= y_high;
            ivia <= is_via; ikind <= source_kind; iid <= shape_id; inv <= new_value;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          match_id <= -32'sd1;
          found <= 1'b0;
          status <= ST_OK;
          state <= S_OUT;
          case (op)
            OP_CLEAR: begin
              shape_count <= '0;
              scan_position <= CAP;
              last_match_index <= '0;
              last_match_valid <= 1'b0;
              lay_valid <= '0;
            end
            OP_ADD: begin
              if (shape_count >= CAP) status <= ST_FULL;
              else begin
                shape_count <= shape_count + 1'b1;
                if (!lay_valid[lay[LW-1:0]]) begin
                  lay_valid[lay[LW-1:0]] <= 1'b1;
                  lxlo[lay[LW-1:0]] <= ixlo; lylo[lay[LW-1:0]] <= iylo;
                  lxhi[lay[LW-1:0]] <= ixhi; lyhi[lay[LW-1:0]] <= iyhi;
                end else begin
                  if (ixlo < lxlo[lay[LW-1:0]]) lxlo[lay[LW-1:0]] <= ixlo;
                  if (iylo < lylo[lay[LW-1:0]]) lylo[lay[LW-1:0]] <= iylo;
                  if (ixhi > lxhi[lay[LW-1:0]]) lxhi[lay[LW-1:0]] <= ixhi;
                  if (iyhi > lyhi[lay[LW-1:0]]) lyhi[lay[LW-1:0]] <= iyhi;
                end
              end
            end
            OP_START: begin
              qry <= '{xlo: ixlo, ylo: iylo, xhi: ixhi, yhi: iyhi, kind: ikind};
              qlayer <= lay;
              last_match_valid <= 1'b0;
              starting <= 1'b1;
              idx <= '0;
              state <= S_READ;
            end
            OP_NEXT: begin
              starting <= 1'b0;
              idx <= scan_position;
              state <= S_READ;
              if (scan_position < shape_count && qry.kind != KIND_VIA &&
                  (lxhi[ql] < qry.xlo || lxlo[ql] > qry.xhi ||
                   lyhi[ql] < qry.ylo || lylo[ql] > qry.yhi)) begin
                scan_position <= CAP;
                state <= S_OUT;
              end
            end
            default: begin
              if (!last_match_valid) status <= ST_NOMATCH;
              state <= S_READ;
            end
          endcase
        end
        S_READ: begin
          // For scans the memory read of entry idx is in flight; edits write the read entry back here.
          if (op == OP_START || op == OP_NEXT) begin
            if (idx >= shape_count) begin
              scan_position <= CAP;
              state <= S_OUT;
            end else state <= S_TEST;
          end else state <= S_OUT;
        end
        S_TEST: begin
          state <= S_READ;
          idx <= idx + 1'b1;
          if (rd_layer == qlayer) begin
            if (starting) begin
              scan_position <= idx;
              state <= S_OUT;
            end else if (hit) begin
              match_id <= rd_shape.ident;
              found <= 1'b1;
              last_match_index <= idx;
              last_match_valid <= 1'b1;
              starting <= 1'b1;
            end
          end
        end
        S_OUT: begin
          if (!out_valid) out_valid <= 1'b1;
          else if (out_ready) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Assertions.
  a_count: assert property (@(posedge clk) disable iff (rst) shape_count <= CAP)
    else $error("shape count beyond capacity");
  a_ready: assert property (@(posedge clk) disable iff (rst) out_valid |-> !in_ready)
    else $error("input taken while result pending");
  a_found: assert property (@(posedge clk) disable iff (rst)
    (out_valid && found) |-> last_match_valid)
    else $error("match without last match");
endmodule
